/* src/punrank_pkg.sv */
// Package for the permutation unranking block: word types and the factorial table.
// No dependencies; permutation_unrank_top imports it.
package punrank_pkg;

  typedef logic [61:0] rank_t;

  typedef struct packed {
    logic [4:0] perm_length;
    rank_t      rank_number;
  } in_word_t;

  typedef struct packed {
    logic [4:0] element_value;
    logic       final_flag;
    logic       rank_error;
  } out_word_t;

  // k! at entry k; lengths above twenty are rejected, so those entries never matter.
  localparam rank_t FACT_TABLE [0:31] = '{
    62'd1, 62'd1, 62'd2, 62'd6, 62'd24, 62'd120, 62'd720, 62'd5040, 62'd40320,
    62'd362880, 62'd3628800, 62'd39916800, 62'd479001600, 62'd6227020800,
    62'd87178291200, 62'd1307674368000, 62'd20922789888000,
    62'd355687428096000, 62'd6402373705728000, 62'd121645100408832000,
    62'd2432902008176640000,
    62'd0, 62'd0, 62'd0, 62'd0, 62'd0, 62'd0, 62'd0, 62'd0, 62'd0, 62'd0, 62'd0
  };

endpackage

/* src/punrank_pick.sv */
// Picks the sel-th set bit (counted from bit 0) of the free-value bitmap.
// Depends on nothing but its parameter; used by permutation_unrank_top.
module punrank_pick #(
  parameter int MAX_LEN = 20
) (
  input  logic [MAX_LEN-1:0] free_map,
  input  logic [4:0]         sel,
  output logic [MAX_LEN-1:0] hit,
  output logic [4:0]         index
);

  // Each bit is judged on its own: it is the pick when it is free and exactly
  // sel free bits lie below it.
  always_comb begin
    logic [MAX_LEN-1:0] below;
    hit   = '0;
    index = '0;
    for (int b = 0; b < MAX_LEN; b++) begin
      below  = free_map & ((MAX_LEN)'(1) << b) - (MAX_LEN)'(1);
      hit[b] = free_map[b] && (5'($countones(below)) == sel);
      if (hit[b]) begin
        index = index | 5'(b);
      end
    end
  end

endmodule

/* src/permutation_unrank_top.sv */
// Top level of the lexicographic permutation unranking block.
// Depends on punrank_pkg and punrank_pick.
//
//   port group   direction  word type    contents
//   in_*         in         in_word_t    length n and one-based rank
//   out_*        out        out_word_t   one element per word, last flagged
//
// Each request goes through setup and a range check, then for each of the n
// elements a restoring division by (n-1-i)! in one shared subtract-and-compare
// unit and a pick of the free value. A rejected request gives one word.
// Reset is synchronous and active low; it empties the output register.
// A stalled output holds the sequencer in its emit or error state; no input is taken
// until the last word of the current request is loaded.
module permutation_unrank_top #(
  parameter int MAX_LEN = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  punrank_pkg::in_word_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output punrank_pkg::out_word_t out_data
);

  import punrank_pkg::*;

  localparam logic [4:0] MAX_N = 5'(MAX_LEN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT,
    ST_ERR
  } state_t;

  state_t             state_r;
  logic [4:0]         n_r;
  logic [4:0]         pos_r;
  rank_t              rank_r;
  rank_t              rem_r;
  rank_t              fact_r;
  logic [MAX_LEN-1:0] free_r;
  logic [2:0]         bit_r;
  logic [4:0]         digit_r;
  logic               out_valid_r;
  out_word_t          out_data_r;

  logic [66:0]        div_shift;
  logic [66:0]        div_diff;
  logic               div_ge;
  logic               range_err;
  logic [MAX_LEN-1:0] init_free;
  logic [MAX_LEN-1:0] pick_hit;
  logic [4:0]         pick_index;
  logic               out_free;
  logic               out_load;
  logic               last_elem;
  logic [4:0]         next_fact_idx;

  punrank_pick #(
    .MAX_LEN(MAX_LEN)
  ) u_pick (
    .free_map(free_r),
    .sel     (digit_r),
    .hit     (pick_hit),
    .index   (pick_index)
  );

  // Shared unit: one trial subtraction of the divisor shifted by the current
  // quotient bit. The quotient never exceeds 19, so five bits suffice.
  assign div_shift = {5'd0, fact_r} << bit_r;
  assign div_diff  = {5'd0, rem_r} - div_shift;
  assign div_ge    = ({5'd0, rem_r} >= div_shift);

  assign range_err = (n_r == 5'd0) || (n_r > MAX_N) || (rank_r == '0) ||
                     (rank_r > FACT_TABLE[n_r]);

  always_comb begin
    for (int b = 0; b < MAX_LEN; b++) begin
      init_free[b] = (5'(b) < n_r);
    end
  end

  assign out_free      = !out_valid_r || out_ready;
  assign out_load      = out_free && ((state_r == ST_EMIT) || (state_r == ST_ERR));
  assign last_elem     = (pos_r == n_r - 5'd1);
  assign next_fact_idx = n_r - pos_r - 5'd2;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            n_r     <= in_data.perm_length;
            rank_r  <= in_data.rank_number;
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (range_err) begin
            state_r <= ST_ERR;
          end else begin
            rem_r   <= rank_r - 62'd1;
            free_r  <= init_free;
            pos_r   <= '0;
            fact_r  <= FACT_TABLE[n_r - 5'd1];
            bit_r   <= 3'd4;
            digit_r <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_ge) begin
            rem_r <= div_diff[61:0];
          end
          digit_r[bit_r] <= div_ge;
          bit_r          <= bit_r - 3'd1;
          if (bit_r == 3'd0) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data_r.element_value   <= pick_index + 5'd1;
            out_data_r.final_flag      <= last_elem;
            out_data_r.rank_error      <= 1'b0;
            free_r                     <= free_r & ~pick_hit;
            pos_r                      <= pos_r + 5'd1;
            if (last_elem) begin
              state_r <= ST_IDLE;
            end else begin
              fact_r  <= FACT_TABLE[next_fact_idx];
              bit_r   <= 3'd4;
              digit_r <= '0;
              state_r <= ST_DIV;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_data_r.element_value <= '0;
            out_data_r.final_flag    <= 1'b1;
            out_data_r.rank_error    <= 1'b1;
            state_r                  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
